### hw/rtl/bpfb_pkg.sv
package bpfb_pkg;

   localparam int unsigned BTN_W   = 31;
   localparam int unsigned SCALE_W = 25;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned CSR_IDX_W = 3;
   // reciprocal quotient bits, one per cell plus the top bit
   localparam int unsigned RECIP_BITS = 33;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd10000000;
   localparam logic [WORD_W-1:0]  Q_GAIN      = 32'd100000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE_X  = 3'd0,
      CSR_SCALE_Y  = 3'd1,
      CSR_OFFSET_X = 3'd2,
      CSR_OFFSET_Y = 3'd3,
      CSR_OFFSET_Q = 3'd4,
      CSR_DIAG     = 3'd5
   } csr_idx_type;

   // data handed from cell to cell along the row
   typedef struct packed {
      logic                valid;
      logic                last;
      logic                diag;
      logic [WORD_W-1:0]   mx;      // differences, wrapping
      logic [WORD_W-1:0]   my;
      logic [WORD_W-1:0]   mq;
      logic [BTN_W-1:0]    sum;
      logic [5:0]          shl;     // 62 - shift
      logic [WORD_W:0]     rem;     // partial remainder
      logic [RECIP_BITS-1:0] quo;   // quotient bits so far
   } bpfb_cell_type;

endpackage

### hw/rtl/bpfb_div_cell.sv
module bpfb_div_cell
   import bpfb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  bpfb_cell_type cell_i,
   output bpfb_cell_type cell_o
);

   bpfb_cell_type cell_ff, cell_in;
   logic [WORD_W+1:0] trial;

   // one restoring division step: shift in a zero, subtract S if it fits
   always_comb begin
      cell_in = cell_i;
      trial   = {cell_i.rem, 1'b0} - {3'b000, cell_i.sum};
      if (!trial[WORD_W+1]) begin
         cell_in.rem = trial[WORD_W:0];
         cell_in.quo = {cell_i.quo[RECIP_BITS-2:0], 1'b1};
      end else begin
         cell_in.rem = {cell_i.rem[WORD_W-1:0], 1'b0};
         cell_in.quo = {cell_i.quo[RECIP_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (advance) begin
         cell_ff.last <= cell_in.last;
         cell_ff.diag <= cell_in.diag;
         cell_ff.mx   <= cell_in.mx;
         cell_ff.my   <= cell_in.my;
         cell_ff.mq   <= cell_in.mq;
         cell_ff.sum  <= cell_in.sum;
         cell_ff.shl  <= cell_in.shl;
         cell_ff.rem  <= cell_in.rem;
         cell_ff.quo  <= cell_in.quo;
      end
   end

   assign cell_o = cell_ff;

endmodule

### hw/rtl/bpfb_scale.sv
module bpfb_scale
   import bpfb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  bpfb_cell_type     cell_i,
   input  logic [SCALE_W-1:0] scale_x,
   input  logic [SCALE_W-1:0] scale_y,
   input  logic [WORD_W-1:0] offset_x,
   input  logic [WORD_W-1:0] offset_y,
   input  logic [WORD_W-1:0] offset_q,
   output logic              out_valid,
   output logic [WORD_W-1:0] pos_x,
   output logic [WORD_W-1:0] pos_y,
   output logic [WORD_W-1:0] skew_q,
   output logic [BTN_W-1:0]  sum_s,
   output logic              sum_zero,
   output logic              last_out
);

   // stage 1: gain times reciprocal, and shifted differences
   logic              v1_ff, l1_ff, d1_ff, z1_ff;
   logic [BTN_W-1:0]  s1_ff;
   logic [WORD_W-1:0] tx1_ff, ty1_ff, tq1_ff, mx1_ff, my1_ff, mq1_ff;
   logic [WORD_W-1:0] inv;
   logic [2*WORD_W-1:0] px, py, pq;

   // quotient is floor(2^shift/S); for S of one the row carries a flag in the
   // top bit instead, and the reciprocal is exactly 2^31
   assign inv = cell_i.quo[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : cell_i.quo[WORD_W-1:0];
   assign px = {32'd0, 5'd0, scale_x, 2'b00} * {32'd0, inv};
   assign py = {32'd0, 5'd0, scale_y, 2'b00} * {32'd0, inv};
   assign pq = {{WORD_W{1'b0}}, Q_GAIN << 2} * {32'd0, inv};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= cell_i.valid;
      end
      if (advance) begin
         l1_ff  <= cell_i.last;
         d1_ff  <= cell_i.diag;
         z1_ff  <= (cell_i.sum == '0);
         s1_ff  <= cell_i.sum;
         tx1_ff <= px[2*WORD_W-1:WORD_W];
         ty1_ff <= py[2*WORD_W-1:WORD_W];
         tq1_ff <= pq[2*WORD_W-1:WORD_W];
         mx1_ff <= cell_i.mx << cell_i.shl;
         my1_ff <= cell_i.my << cell_i.shl;
         mq1_ff <= cell_i.mq << cell_i.shl;
      end
   end

   // stage 2: unsigned by signed product, high word
   logic              v2_ff, l2_ff, d2_ff, z2_ff;
   logic [BTN_W-1:0]  s2_ff;
   logic [WORD_W-1:0] hx2_ff, hy2_ff, hq2_ff;
   logic signed [2*WORD_W+1:0] rx, ry, rq;

   assign rx = $signed({2'b00, tx1_ff}) * $signed({{2{mx1_ff[WORD_W-1]}}, mx1_ff});
   assign ry = $signed({2'b00, ty1_ff}) * $signed({{2{my1_ff[WORD_W-1]}}, my1_ff});
   assign rq = $signed({2'b00, tq1_ff}) * $signed({{2{mq1_ff[WORD_W-1]}}, mq1_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         l2_ff  <= l1_ff;
         d2_ff  <= d1_ff;
         z2_ff  <= z1_ff;
         s2_ff  <= s1_ff;
         hx2_ff <= rx[2*WORD_W-1:WORD_W];
         hy2_ff <= ry[2*WORD_W-1:WORD_W];
         hq2_ff <= rq[2*WORD_W-1:WORD_W];
      end
   end

   // stage 3: doubling (non-diagonal layout only), offsets, zero-sum forcing
   logic [WORD_W-1:0] ax, ay;
   logic              v3_ff, l3_ff, z3_ff;
   logic [BTN_W-1:0]  s3_ff;
   logic [WORD_W-1:0] x3_ff, y3_ff, q3_ff;

   assign ax = d2_ff ? hx2_ff : {hx2_ff[WORD_W-2:0], 1'b0};
   assign ay = d2_ff ? hy2_ff : {hy2_ff[WORD_W-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         l3_ff <= l2_ff;
         z3_ff <= z2_ff;
         s3_ff <= s2_ff;
         x3_ff <= z2_ff ? '0 : ax - offset_x;
         y3_ff <= z2_ff ? '0 : ay - offset_y;
         q3_ff <= z2_ff ? '0 : hq2_ff - offset_q;
      end
   end

   assign out_valid = v3_ff;
   assign pos_x     = x3_ff;
   assign pos_y     = y3_ff;
   assign skew_q    = q3_ff;
   assign sum_s     = s3_ff;
   assign sum_zero  = z3_ff;
   assign last_out  = l3_ff;

endmodule

### hw/rtl/beam_position_from_buttons_core.sv
// Beam position from four button intensities, difference over sum.
// Request channel req_*: four 31 bit button intensities and last_in.
// Response channel rsp_*: pos_x, pos_y, skew_q, sum_s, sum_zero, last_out,
// one response per request, in order.
// Configuration channel csr_*: index and data; write only while idle.
// One request per cycle is accepted while the pipeline advances. A response
// passes through one entry register, a row of 32 division cells each
// resolving one reciprocal bit, and three scaling stages.
// The whole pipeline advances while the output register is empty or
// being taken; when the receiver stalls with a response held, the row
// freezes and req_ready falls.
// Reset empties the pipeline and loads register defaults (scale 10000000,
// offsets 0, diagonal layout).
module beam_position_from_buttons_core
   import bpfb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BTN_W-1:0]     req_button_a,
   input  logic [BTN_W-1:0]     req_button_b,
   input  logic [BTN_W-1:0]     req_button_c,
   input  logic [BTN_W-1:0]     req_button_d,
   input  logic                 req_last_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_W-1:0]    rsp_pos_x,
   output logic [WORD_W-1:0]    rsp_pos_y,
   output logic [WORD_W-1:0]    rsp_skew_q,
   output logic [BTN_W-1:0]     rsp_sum_s,
   output logic                 rsp_sum_zero,
   output logic                 rsp_last_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   logic [SCALE_W-1:0] scale_x_ff, scale_y_ff;
   logic [WORD_W-1:0]  offset_x_ff, offset_y_ff, offset_q_ff;
   logic               diag_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff  <= SCALE_RESET;
         scale_y_ff  <= SCALE_RESET;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_q_ff <= '0;
         diag_ff     <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SCALE_X:  scale_x_ff  <= csr_data[SCALE_W-1:0];
            CSR_SCALE_Y:  scale_y_ff  <= csr_data[SCALE_W-1:0];
            CSR_OFFSET_X: offset_x_ff <= csr_data;
            CSR_OFFSET_Y: offset_y_ff <= csr_data;
            CSR_OFFSET_Q: offset_q_ff <= csr_data;
            CSR_DIAG:     diag_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic advance;
   logic out_valid;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // entry: prescale, sum, differences, shift selection
   logic [BTN_W-1:0]  a, b, c, d;
   logic [WORD_W-1:0] aw, bw, cw, dw;
   logic [BTN_W-1:0]  s;
   logic [5:0]        nbits;
   logic              pow2;
   logic [5:0]        shift;
   bpfb_cell_type     head_in, head_ff;

   assign a = {2'b00, req_button_a[BTN_W-1:2]};
   assign b = {2'b00, req_button_b[BTN_W-1:2]};
   assign c = {2'b00, req_button_c[BTN_W-1:2]};
   assign d = {2'b00, req_button_d[BTN_W-1:2]};
   assign aw = {1'b0, a};
   assign bw = {1'b0, b};
   assign cw = {1'b0, c};
   assign dw = {1'b0, d};
   assign s  = a + b + c + d;
   assign pow2 = (s & (s - BTN_W'(1))) == '0;

   always_comb begin
      nbits = '0;
      for (int i = 0; i < BTN_W; i++) begin
         if (s[i]) nbits = 6'(i + 1);
      end
   end

   // shift = 31 + ceil(log2 S); dividend 2^shift scaled so the row
   // starts from remainder 2^(shift-32) relative to S
   assign shift = pow2 ? 6'd30 + nbits : 6'd31 + nbits;

   always_comb begin
      head_in       = '0;
      head_in.valid = req_valid;
      head_in.last  = req_last_in;
      head_in.diag  = diag_ff;
      head_in.mx    = diag_ff ? aw - bw - cw + dw : dw - bw;
      head_in.my    = diag_ff ? aw + bw - cw - dw : aw - cw;
      head_in.mq    = aw - bw + cw - dw;
      head_in.sum   = s;
      head_in.shl   = 6'd62 - shift;
      // initial remainder: 2^(shift-32) < S for every S above one
      head_in.rem   = (s == '0) ? '0 : (33'd1 << (shift - 6'd32));
      head_in.quo   = '0;
      // S of one: the leading bit cannot start the row, so flag it; the
      // flag reaches the top quotient bit after the last cell
      head_in.quo[0] = (s == BTN_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff.valid <= head_in.valid;
      end
      if (advance) begin
         head_ff.last <= head_in.last;
         head_ff.diag <= head_in.diag;
         head_ff.mx   <= head_in.mx;
         head_ff.my   <= head_in.my;
         head_ff.mq   <= head_in.mq;
         head_ff.sum  <= head_in.sum;
         head_ff.shl  <= head_in.shl;
         head_ff.rem  <= head_in.rem;
         head_ff.quo  <= head_in.quo;
      end
   end

   // row of division cells, 32 quotient bits below the leading one
   localparam int unsigned NCELL = RECIP_BITS - 1;
   bpfb_cell_type chain [NCELL+1];
   assign chain[0] = head_ff;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      bpfb_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cell_i  (chain[g]),
         .cell_o  (chain[g+1])
      );
   end

   bpfb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cell_i    (chain[NCELL]),
      .scale_x   (scale_x_ff),
      .scale_y   (scale_y_ff),
      .offset_x  (offset_x_ff),
      .offset_y  (offset_y_ff),
      .offset_q  (offset_q_ff),
      .out_valid (out_valid),
      .pos_x     (rsp_pos_x),
      .pos_y     (rsp_pos_y),
      .skew_q    (rsp_skew_q),
      .sum_s     (rsp_sum_s),
      .sum_zero  (rsp_sum_zero),
      .last_out  (rsp_last_out)
   );

   assign rsp_valid = out_valid;

   // a held response stays valid and its pos_x does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x))
      else $error("response changed while stalled");
   // zero sum forces zero pos_x and skew_q
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sum_zero |-> rsp_pos_x == '0 && rsp_skew_q == '0)
      else $error("zero sum with nonzero position");
   // flag agrees with sum
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sum_zero == (rsp_sum_s == '0))
      else $error("sum_zero disagrees with sum");
   // stall blocks requests
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken during stall");

endmodule
